>>> rtl/core/sine_lut_phase_oscillator_defines.svh
// Assertion macros shared by the oscillator checker
`ifndef SINE_LUT_PHASE_OSCILLATOR_DEFINES_SVH
`define SINE_LUT_PHASE_OSCILLATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SINOSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SINOSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sinosc_pkg.sv
// Shared types, constants and sine table generator for the phase oscillator
package sinosc_pkg;

    localparam int unsigned TABLE_HALF  = 512;
    localparam int unsigned QUARTER_LEN = TABLE_HALF / 2;
    localparam int unsigned IDX_W       = $clog2(2 * TABLE_HALF + 1);
    localparam int unsigned BASE_W      = $clog2(2 * TABLE_HALF);
    localparam int unsigned PROD_W      = 31 + BASE_W;
    localparam int unsigned QIDX_W      = $clog2(QUARTER_LEN);
    localparam int unsigned J_W         = $clog2(QUARTER_LEN + 1);

    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned FRAC_W   = 31;
    localparam int unsigned RATE_W   = 33;
    localparam int unsigned FM_W     = 32;
    localparam int unsigned INC_W    = 34;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned DIFF_W   = 17;
    localparam int unsigned MUL_W    = 48;
    localparam int unsigned SUM_W    = 18;

    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned REG_SEL_BIT = 3;
    localparam logic        REG_RATE    = 1'b0;

    localparam logic signed [RATE_W-1:0]   RATE_MAX   = 33'sh0_8000_0000;
    localparam logic signed [RATE_W-1:0]   RATE_MIN   = 33'sh1_8000_0000;
    localparam logic signed [RATE_W-1:0]   RATE_RESET = 33'sh0_8000_0000;
    localparam logic signed [INC_W-1:0]    INC_MIN    = 34'sh3_0000_0001;
    localparam logic signed [MUL_W-1:0]    ROUND_HALF = 48'sh0000_4000_0000;
    localparam logic signed [SUM_W-1:0]    SAMPLE_MAX = 18'sh0_7FFF;
    localparam logic signed [SUM_W-1:0]    SAMPLE_MIN = 18'sh3_8000;
    localparam logic [63:0]                PI_Q30     = 64'd3373259426;

    typedef enum logic
    {
        OP_STEP    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        CROSS_NONE = 2'd0,
        CROSS_ZERO = 2'd1,
        CROSS_PEAK = 2'd2
    } crossing_t;

    typedef struct packed
    {
        logic                 valid;
        crossing_t            crossing;
        logic [PHASE_W-1:0]   phase;
    } sinosc_step_t;

    // shift-subtract quotient for the table generator
    function automatic longint unsigned div_u64(input longint unsigned n,
                                                input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave magnitude in Q0.15 from a Q30 Taylor series
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned k;
        longint unsigned mag;
        longint          sum;
        x    = div_u64(PI_Q30 * j, TABLE_HALF);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (k = 1; k <= 10; k++)
        begin
            term = (term * x2) >> 30;
            term = div_u64(term, (2 * k) * (2 * k + 1));
            if (k[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = (unsigned'(sum) + 64'd16384) >> 15;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return mag[MAG_W-1:0];
    endfunction

    localparam logic [MAG_W-1:0] TOP_MAG = sine_mag(QUARTER_LEN);

endpackage

>>> rtl/core/sinosc_rom.sv
// Full-wave sine table lookup folded onto a quarter-wave constant table
module sinosc_rom
    import sinosc_pkg::*;
(
    input  logic [IDX_W-1:0]           idx,
    output logic signed [SAMPLE_W-1:0] value
);

    logic [MAG_W-1:0] quarter [QUARTER_LEN];
    logic             neg;
    logic [IDX_W-1:0] half_idx;
    logic [IDX_W-1:0] fold_idx;
    logic [J_W-1:0]   j;
    logic [MAG_W-1:0] mag;

    for (genvar g = 0; g < QUARTER_LEN; g++)
    begin : g_quarter
        localparam logic [MAG_W-1:0] MAG = sine_mag(g);
        assign quarter[g] = MAG;
    end

    always_comb
    begin
        neg      = (idx >= IDX_W'(TABLE_HALF));
        half_idx = neg ? (idx - IDX_W'(TABLE_HALF)) : idx;
        if ({half_idx, 1'b0} > (IDX_W + 1)'(TABLE_HALF))
            fold_idx = IDX_W'(TABLE_HALF) - half_idx;
        else
            fold_idx = half_idx;
        j = J_W'(fold_idx);
        if (j == J_W'(QUARTER_LEN))
            mag = TOP_MAG;
        else
            mag = quarter[j[QIDX_W-1:0]];
        value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

>>> rtl/core/sinosc_phase.sv
// Input register and phase accumulator with saturation, wrap and crossing detect
module sinosc_phase
    import sinosc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic                      opcode,
    input  logic signed [FM_W-1:0]    fm,
    input  logic signed [RATE_W-1:0]  rate,
    input  logic                      step_ready,
    output sinosc_step_t              step
);

    logic                     a_valid_reg;
    opcode_t                  a_op_reg;
    logic signed [FM_W-1:0]   a_fm_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [PHASE_W-1:0]       phase_next;
    logic                     step_valid_reg;
    logic [PHASE_W-1:0]       step_phase_reg;
    crossing_t                step_cross_reg;
    crossing_t                cross_next;

    logic                     ld_a;
    logic                     ld_b;
    logic signed [INC_W-1:0]  inc_sum;
    logic signed [INC_W-1:0]  inc;
    logic signed [INC_W:0]    next_sum;

    assign ld_b       = !step_valid_reg || step_ready;
    assign ld_a       = !a_valid_reg || ld_b;
    assign item_stall = !ld_a;

    always_comb
    begin
        inc_sum = INC_W'(rate) + INC_W'(a_fm_reg);
        if (inc_sum < INC_MIN)
            inc = INC_MIN;
        else
            inc = inc_sum;
        next_sum = $signed({3'b000, phase_reg}) + $signed({inc[INC_W-1], inc});

        if (!next_sum[INC_W] && next_sum[PHASE_W])
            cross_next = CROSS_ZERO;
        else if (!next_sum[INC_W] && next_sum[PHASE_W-1] && !phase_reg[PHASE_W-1])
            cross_next = CROSS_PEAK;
        else if (next_sum[INC_W])
            cross_next = CROSS_ZERO;
        else
            cross_next = CROSS_NONE;

        phase_next = phase_reg;
        if (a_valid_reg && ld_b)
        begin
            if (a_op_reg == OP_RESTART)
                phase_next = '0;
            else
                phase_next = next_sum[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            phase_reg      <= '0;
            step_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (ld_a)
                a_valid_reg <= item_valid;
            if (ld_b)
                step_valid_reg <= a_valid_reg && (a_op_reg == OP_STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a && item_valid)
        begin
            a_op_reg <= opcode_t'(opcode);
            a_fm_reg <= fm;
        end
        if (ld_b)
        begin
            step_phase_reg <= next_sum[PHASE_W-1:0];
            step_cross_reg <= cross_next;
        end
    end

    assign step.valid    = step_valid_reg;
    assign step.crossing = step_cross_reg;
    assign step.phase    = step_phase_reg;

endmodule

>>> rtl/core/sinosc_interp.sv
// Table index, lookup, interpolation multiply and output register stages
module sinosc_interp
    import sinosc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sinosc_step_t               step,
    output logic                       step_ready,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [1:0]                 crossing
);

    logic                       c_valid_reg;
    logic [BASE_W-1:0]          c_base_reg;
    logic [FRAC_W-1:0]          c_frac_reg;
    crossing_t                  c_cross_reg;

    logic                       d_valid_reg;
    logic signed [SAMPLE_W-1:0] d_lo_reg;
    logic signed [SAMPLE_W-1:0] d_hi_reg;
    logic [FRAC_W-1:0]          d_frac_reg;
    crossing_t                  d_cross_reg;

    logic                       e_valid_reg;
    logic signed [SAMPLE_W-1:0] e_lo_reg;
    logic signed [MUL_W-1:0]    e_prod_reg;
    crossing_t                  e_cross_reg;

    logic                       o_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    crossing_t                  crossing_reg;

    logic                       ld_c;
    logic                       ld_d;
    logic                       ld_e;
    logic                       ld_o;

    logic [PROD_W-1:0]          scaled;
    logic [IDX_W-1:0]           lo_idx;
    logic [IDX_W-1:0]           hi_idx;
    logic signed [SAMPLE_W-1:0] lo_val;
    logic signed [SAMPLE_W-1:0] hi_val;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PHASE_W-1:0]  frac_s;
    logic signed [MUL_W:0]      prod_full;
    logic signed [MUL_W-1:0]    rounded;
    logic signed [SUM_W-1:0]    sum;

    assign ld_o       = !o_valid_reg || !result_stall;
    assign ld_e       = !e_valid_reg || ld_o;
    assign ld_d       = !d_valid_reg || ld_e;
    assign ld_c       = !c_valid_reg || ld_d;
    assign step_ready = ld_c;

    assign scaled = PROD_W'(step.phase) * PROD_W'(TABLE_HALF);
    assign lo_idx = IDX_W'(c_base_reg);
    assign hi_idx = IDX_W'(c_base_reg) + IDX_W'(1);

    sinosc_rom u_rom_lo
    (
        .idx   (lo_idx),
        .value (lo_val)
    );

    sinosc_rom u_rom_hi
    (
        .idx   (hi_idx),
        .value (hi_val)
    );

    always_comb
    begin
        diff      = DIFF_W'(d_hi_reg) - DIFF_W'(d_lo_reg);
        frac_s    = $signed({1'b0, d_frac_reg});
        prod_full = diff * frac_s;
        rounded   = e_prod_reg + ROUND_HALF;
        sum       = SUM_W'(e_lo_reg) + SUM_W'($signed(rounded[MUL_W-1:FRAC_W]));
        if (sum > SAMPLE_MAX)
            sample_next = SAMPLE_MAX[SAMPLE_W-1:0];
        else if (sum < SAMPLE_MIN)
            sample_next = SAMPLE_MIN[SAMPLE_W-1:0];
        else
            sample_next = sum[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld_c)
                c_valid_reg <= step.valid;
            if (ld_d)
                d_valid_reg <= c_valid_reg;
            if (ld_e)
                e_valid_reg <= d_valid_reg;
            if (ld_o)
                o_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_c)
        begin
            c_base_reg  <= scaled[PROD_W-1:FRAC_W];
            c_frac_reg  <= scaled[FRAC_W-1:0];
            c_cross_reg <= step.crossing;
        end
        if (ld_d)
        begin
            d_lo_reg    <= lo_val;
            d_hi_reg    <= hi_val;
            d_frac_reg  <= c_frac_reg;
            d_cross_reg <= c_cross_reg;
        end
        if (ld_e)
        begin
            e_lo_reg    <= d_lo_reg;
            e_prod_reg  <= prod_full[MUL_W-1:0];
            e_cross_reg <= d_cross_reg;
        end
        if (ld_o)
        begin
            sample_reg   <= sample_next;
            crossing_reg <= e_cross_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign sample       = sample_reg;
    assign crossing     = crossing_reg;

endmodule

>>> rtl/core/sine_lut_phase_oscillator.sv
// Phase-accumulator sine oscillator: one transaction per clock while item_stall
// is low. The rate is one item per cycle when nothing stalls, set by the phase
// accumulator, which closes its add, saturate and wrap loop through phase_reg;
// the table index, table lookup, interpolation multiply and output rounding
// each take a pipeline stage behind it. A restart transaction clears the phase
// and returns nothing. The rate register is decoded on paddr[3] = 0 (byte
// addresses 0x0-0x7; 33-bit signed, 1.0 = 2^31, clamped to [-1, 1] on write,
// reset 1.0); writes with paddr[3] set are ignored. Stalls move back through
// the stages, so items keep being accepted while any stage is empty.
module sine_lut_phase_oscillator
    import sinosc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       opcode,
    input  logic signed [FM_W-1:0]     fm,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [1:0]                 crossing
);

    logic signed [RATE_W-1:0] rate_reg;
    logic signed [RATE_W-1:0] rate_next;
    logic signed [RATE_W-1:0] wdata;
    logic                     cfg_wr;
    sinosc_step_t             step;
    logic                     step_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[REG_SEL_BIT] == REG_RATE);
    assign wdata  = $signed(pwdata[RATE_W-1:0]);

    always_comb
    begin
        rate_next = rate_reg;
        if (cfg_wr)
        begin
            if (wdata > RATE_MAX)
                rate_next = RATE_MAX;
            else if (wdata < RATE_MIN)
                rate_next = RATE_MIN;
            else
                rate_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= RATE_RESET;
        else
            rate_reg <= rate_next;
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_RATE)
                  ? {{(DATA_W - RATE_W){rate_reg[RATE_W-1]}}, rate_reg}
                  : '0;

    sinosc_phase u_phase
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .fm         (fm),
        .rate       (rate_reg),
        .step_ready (step_ready),
        .step       (step)
    );

    sinosc_interp u_interp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .step_ready   (step_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .crossing     (crossing)
    );

endmodule

>>> rtl/core/sinosc_chk.sv
// Port-level assertion checker for the oscillator and its bind
`include "sine_lut_phase_oscillator_defines.svh"

module sinosc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata,
    input logic        pready,
    input logic        item_valid,
    input logic        item_stall,
    input logic        opcode,
    input logic [31:0] fm,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] sample,
    input logic [1:0]  crossing
);

    `SINOSC_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(sample) && $stable(crossing), "stalled result changed or dropped")
    `SINOSC_ASSERT_IMP(a_no_stall_when_free, !result_valid || !result_stall, !item_stall, "input stalled while output stage is free")
    `SINOSC_ASSERT_IMP(a_sample_floor, result_valid, sample != 16'h8000, "interpolated sample below table minimum")
    `SINOSC_ASSERT_NXT(a_rate_readback, psel && penable && pwrite && !paddr[3] && (pwdata[32] == pwdata[31]), paddr[3] || (prdata[32:0] == $past(pwdata[32:0])), "in-range rate write not read back")

endmodule

bind sine_lut_phase_oscillator sinosc_chk u_sinosc_chk (.*);

>>> tb/sv/sine_lut_phase_oscillator_tb.sv
// Self-checking testbench for the LUT sine phase oscillator with an APB rate register
module sine_lut_phase_oscillator_tb;
    import sinosc_pkg::*;

    localparam int                CYCLE_LIMIT    = 200000;
    localparam int                DRAIN_CYCLES   = 10;
    localparam int                LONG_HOLD      = 150;
    localparam int                HOLD_AT_FIRST  = 150;
    localparam int                HOLD_AT_SECOND = 600;
    localparam int                RAND_PHASES    = 8;
    localparam int                PHASE_ITEMS    = 112;
    localparam logic [ADDR_W-1:0] RATE_ADDR      = 4'h0;
    localparam logic [ADDR_W-1:0] UNUSED_ADDR    = 4'h8;
    localparam longint unsigned   SIN_PI_Q30     = 64'd3373259426;
    localparam longint            INC_LIMIT      = 64'sd4294967295;
    localparam longint            PHASE_SPAN     = 64'sd4294967296;
    localparam longint            HALF_SPAN      = 64'sd2147483648;
    localparam longint            ROUND_Q31      = 64'sd1073741824;
    localparam longint            LAST_BASE      = 2 * TABLE_HALF - 1;

    typedef struct
    {
        opcode_t                op;
        logic signed [FM_W-1:0] fm;
    } osc_item_t;

    typedef struct
    {
        logic signed [SAMPLE_W-1:0] sample;
        crossing_t                  crossing;
    } osc_out_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic                       opcode = 1'b0;
    logic signed [FM_W-1:0]     fm = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic [1:0]                 crossing;

    shortint          sine_table [0:2*TABLE_HALF];
    logic [31:0]      model_phase = '0;
    longint           model_rate = HALF_SPAN;
    osc_item_t        items_to_send [$];
    osc_out_t         samples_due [$];
    osc_item_t        cur_item;
    osc_out_t         predicted;
    osc_out_t         oldest;
    bit               no_idle = 1'b0;
    int unsigned      send_wait = 0;
    int unsigned      recv_wait = 0;
    int unsigned      recv_draw;
    int unsigned      hold_left = 0;
    int unsigned      results_seen = 0;
    int unsigned      mismatches = 0;
    int unsigned      cycles = 0;

    sine_lut_phase_oscillator dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .fm           (fm),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .crossing     (crossing)
    );

    always #6 clk = ~clk;

    function automatic shortint sine_entry(input int i);
        longint unsigned j;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned mag;
        longint          acc;
        bit              neg;
        j   = i;
        neg = 1'b0;
        if (j >= TABLE_HALF)
        begin
            neg = 1'b1;
            j   = j - TABLE_HALF;
        end
        if (2 * j > TABLE_HALF)
            j = TABLE_HALF - j;
        x    = (SIN_PI_Q30 * j) / TABLE_HALF;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 10; k++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'(4 * k * k + 2 * k);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        mag = (longint'(acc) + 64'd16384) >> 15;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return neg ? -shortint'(mag) : shortint'(mag);
    endfunction

    function automatic longint clamp_rate(input logic [DATA_W-1:0] data);
        logic signed [RATE_W-1:0] r33;
        longint                   r;
        r33 = data[RATE_W-1:0];
        r   = r33;
        if (r > HALF_SPAN)
            r = HALF_SPAN;
        if (r < -HALF_SPAN)
            r = -HALF_SPAN;
        return r;
    endfunction

    function automatic bit osc_step(input osc_item_t it, output osc_out_t r);
        longint inc;
        longint nxt;
        longint old;
        longint p;
        longint base;
        longint frac;
        longint lo;
        longint hi;
        longint d;
        longint v;
        r.sample   = '0;
        r.crossing = CROSS_NONE;
        if (it.op == OP_RESTART)
        begin
            model_phase = '0;
            return 1'b0;
        end
        inc = model_rate + longint'(it.fm);
        if (inc > INC_LIMIT)
            inc = INC_LIMIT;
        if (inc < -INC_LIMIT)
            inc = -INC_LIMIT;
        old = longint'(model_phase);
        nxt = old + inc;
        if (nxt >= PHASE_SPAN)
        begin
            nxt        = nxt - PHASE_SPAN;
            r.crossing = CROSS_ZERO;
        end
        else if (nxt >= HALF_SPAN && old < HALF_SPAN)
            r.crossing = CROSS_PEAK;
        else if (nxt < 0)
        begin
            nxt        = nxt + PHASE_SPAN;
            r.crossing = CROSS_ZERO;
        end
        model_phase = nxt[31:0];
        p    = longint'(model_phase) * longint'(TABLE_HALF);
        base = p >>> 31;
        frac = p & 64'sh7FFF_FFFF;
        if (base > LAST_BASE)
            base = LAST_BASE;
        lo = sine_table[base];
        hi = sine_table[base + 1];
        d  = (hi - lo) * frac + ROUND_Q31;
        v  = lo + (d >>> 31);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        r.sample = v[SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    function automatic int unsigned idle_draw();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic osc_item_t make_item(input opcode_t op, input logic signed [FM_W-1:0] f);
        osc_item_t it;
        it.op = op;
        it.fm = f;
        return it;
    endfunction

    function automatic osc_item_t rand_item();
        osc_item_t   it;
        logic [31:0] r;
        r     = $urandom;
        it.op = ($urandom_range(0, 99) < 6) ? OP_RESTART : OP_STEP;
        case ($urandom_range(0, 9))
            0:       it.fm = '0;
            1:       it.fm = 32'sh7FFF_FFFF;
            2:       it.fm = 32'sh8000_0000;
            3, 4:    it.fm = {{12{r[19]}}, r[19:0]};
            5:       it.fm = {{4{r[27]}}, r[27:0]};
            default: it.fm = r;
        endcase
        return it;
    endfunction

    function automatic logic [DATA_W-1:0] rand_rate();
        logic [DATA_W-1:0] v;
        logic [31:0]       r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       v = {$urandom, $urandom};
            1:       v = 64'h0000_0000_8000_0000;
            2:       v = 64'hFFFF_FFFF_8000_0000;
            3:       v = '0;
            4:       v = {{40{r[23]}}, r[23:0]};
            default: v = {{32{r[31]}}, r};
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == RATE_ADDR)
            model_rate = clamp_rate(data);
    endtask

    task automatic drain();
        @(negedge clk);
        while (items_to_send.size() != 0 || item_valid || samples_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic note_bad(input string what, input osc_out_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected sample %0d crossing %0d, got sample %0d crossing %0d",
                     what, want.sample, want.crossing, sample, crossing);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_wait  <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid && osc_step(cur_item, predicted))
                samples_due.push_back(predicted);
            if (send_wait != 0)
            begin
                send_wait  <= send_wait - 1;
                item_valid <= 1'b0;
            end
            else if (items_to_send.size() != 0)
            begin
                cur_item   = items_to_send.pop_front();
                opcode     <= cur_item.op;
                fm         <= cur_item.fm;
                item_valid <= 1'b1;
                send_wait  <= idle_draw();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_wait    <= 0;
            hold_left    <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (samples_due.size() == 0)
                begin
                    oldest.sample   = '0;
                    oldest.crossing = CROSS_NONE;
                    note_bad("unexpected transaction", oldest);
                end
                else
                begin
                    oldest = samples_due.pop_front();
                    if (sample !== oldest.sample || crossing !== oldest.crossing)
                        note_bad("wrong transaction", oldest);
                end
            end
            if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
                begin
                    hold_left    <= LONG_HOLD;
                    result_stall <= 1'b1;
                end
                else
                begin
                    recv_draw     = idle_draw();
                    result_stall <= (recv_draw != 0);
                    recv_wait    <= (recv_draw != 0) ? recv_draw - 1 : 0;
                end
            end
            else if (recv_wait != 0)
            begin
                recv_wait    <= recv_wait - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("sine_lut_phase_oscillator: mismatch");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i <= 2 * TABLE_HALF; i++)
            sine_table[i] = sine_entry(i);
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        items_to_send.push_back(make_item(OP_RESTART, 32'sh1234_5678));
        items_to_send.push_back(make_item(OP_STEP, 32'shFFFF_FFFF));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0001));
        items_to_send.push_back(make_item(OP_STEP, 32'sh7FFF_FFFF));
        items_to_send.push_back(make_item(OP_STEP, 32'sh8000_0000));
        items_to_send.push_back(make_item(OP_RESTART, 32'shFFFF_FFFF));
        drain();

        write_reg(RATE_ADDR, 64'h0000_0000_FFFF_FFFF);
        items_to_send.push_back(make_item(OP_STEP, 32'sh7FFF_FFFF));
        items_to_send.push_back(make_item(OP_STEP, 32'sh7FFF_FFFF));
        items_to_send.push_back(make_item(OP_STEP, 32'sh8000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        drain();

        write_reg(RATE_ADDR, 64'h0000_0001_0000_0000);
        items_to_send.push_back(make_item(OP_STEP, 32'sh8000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'shFFFF_FFFF));
        items_to_send.push_back(make_item(OP_RESTART, 32'sh0000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        drain();

        write_reg(UNUSED_ADDR, {$urandom, $urandom});
        write_reg(RATE_ADDR, 64'h0);
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0000));
        items_to_send.push_back(make_item(OP_STEP, 32'sh0000_0001));
        items_to_send.push_back(make_item(OP_STEP, 32'shFFFF_FFFF));
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if ($urandom_range(0, 3) == 0)
                write_reg(UNUSED_ADDR, {$urandom, $urandom});
            write_reg(RATE_ADDR, rand_rate());
            no_idle = (ph == 2 || ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
                items_to_send.push_back(rand_item());
            drain();
        end

        if (mismatches == 0 && samples_due.size() == 0)
            $display("sine_lut_phase_oscillator: match");
        else
            $display("sine_lut_phase_oscillator: mismatch");
        $finish;
    end

endmodule

>>> sine_lut_phase_oscillator.f
+incdir+rtl/core
rtl/core/sinosc_pkg.sv
rtl/core/sinosc_rom.sv
rtl/core/sinosc_phase.sv
rtl/core/sinosc_interp.sv
rtl/core/sine_lut_phase_oscillator.sv
rtl/core/sinosc_chk.sv
tb/sv/sine_lut_phase_oscillator_tb.sv
